>>> rtl/core/motor_feedback_frame_collector_assert.svh
// Assertion macros shared by the checkers of the feedback frame collector.
// Every check is sampled on the rising edge of i_clk and is off during reset.
`ifndef MOTOR_FEEDBACK_FRAME_COLLECTOR_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_COLLECTOR_ASSERT_SVH

// Concurrent check with a generic failure message.
`define MFC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mfc check failed");

// Concurrent check with a caller-supplied failure message.
`define MFC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

>>> rtl/core/mfc_pkg.sv
package mfc_pkg;

    // Number of motors on the bus and the widths that follow from it.
    localparam int MOTOR_COUNT = 6;
    localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int MASK_W      = 2 * MOTOR_COUNT;

    // Frame constants.
    localparam logic [7:0] HDR_FIRST      = 8'h08;
    localparam logic [7:0] HDR_SECOND     = 8'h00;
    localparam logic [7:0] ID_SPEED_BASE  = 8'h72;
    localparam logic [7:0] ID_STATUS_BASE = 8'h52;

    // Stream widths.
    localparam int IN_DATA_W  = 88;
    localparam int RES_W      = 118;
    localparam int OUT_DATA_W = 120;

    // Configuration register map.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 8'd1;
    localparam logic [15:0] JUMP_LIMIT_RST  = 16'd500;
    localparam logic [7:0]  TEMP_OFFSET_RST = 8'd50;

    // Command queue between the front and the back; depth must be at least two.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic {
        KIND_SPEED,
        KIND_STATUS
    } t_kind;

    // One classified frame, ready to be applied to the motor store.
    typedef struct packed {
        t_kind             kind;
        logic [MIDX_W-1:0] motor;
        logic [63:0]       payload;
    } t_cmd;

    // Configuration write transaction.
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // One result; the last member sits in the lowest bits.
    typedef struct packed {
        logic [15:0]        odometer_raw;
        logic signed [8:0]  driver_temp;
        logic signed [8:0]  motor_temp;
        logic [31:0]        fault_code;
        logic signed [31:0] torque_q16;
        logic               speed_rejected;
        logic signed [15:0] speed_rpm;
        logic [2:0]         motor_index;
    } t_result;

endpackage

>>> rtl/core/mfc_front.sv
module mfc_front import mfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output t_cmd                 o_cmd
);

    logic [7:0]  w_hdr_first;
    logic [7:0]  w_hdr_second;
    logic [7:0]  w_id;
    logic [63:0] w_payload;
    logic        w_hdr_ok;
    logic        w_speed_hit;
    logic        w_status_hit;
    logic        w_accept;
    logic        r_valid;
    t_cmd        r_cmd;

    // Unpack the incoming frame.
    assign w_hdr_first  = i_s_tdata[7:0];
    assign w_hdr_second = i_s_tdata[15:8];
    assign w_id         = i_s_tdata[23:16];
    assign w_payload    = i_s_tdata[87:24];

    // Classify by header and message id.
    assign w_hdr_ok     = (w_hdr_first == HDR_FIRST) && (w_hdr_second == HDR_SECOND);
    assign w_speed_hit  = (w_id >= ID_SPEED_BASE) &&
                          (w_id < 8'(ID_SPEED_BASE + MOTOR_COUNT));
    assign w_status_hit = (w_id >= ID_STATUS_BASE) &&
                          (w_id < 8'(ID_STATUS_BASE + MOTOR_COUNT));

    assign o_s_tready = !r_valid || i_cmd_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Output stage: frames that are not for us are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_hdr_ok && (w_speed_hit || w_status_hit);
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.payload <= w_payload;
            if (w_speed_hit) begin
                r_cmd.kind  <= KIND_SPEED;
                r_cmd.motor <= MIDX_W'(w_id - ID_SPEED_BASE);
            end else begin
                r_cmd.kind  <= KIND_STATUS;
                r_cmd.motor <= MIDX_W'(w_id - ID_STATUS_BASE);
            end
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

>>> rtl/core/mfc_queue.sv
module mfc_queue import mfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop        = r_mem[r_rptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push;
        end
    end

endmodule

>>> rtl/core/mfc_back.sv
module mfc_back import mfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res,
    output logic    o_res_last
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [MIDX_W-1:0]   r_cnt;
    logic [MASK_W-1:0]   r_mask;
    logic                r_out_valid;
    t_result             r_out;
    logic                r_out_last;
    logic [15:0]         r_jump_limit;
    logic [7:0]          r_temp_offset;

    logic [31:0]         r_raw_speed   [MOTOR_COUNT];
    logic [31:0]         r_raw_torque  [MOTOR_COUNT];
    logic [31:0]         r_fault_words [MOTOR_COUNT];
    logic [7:0]          r_motor_temp  [MOTOR_COUNT];
    logic [7:0]          r_driver_temp [MOTOR_COUNT];
    logic [15:0]         r_odometer    [MOTOR_COUNT];
    logic signed [15:0]  r_acc_speed   [MOTOR_COUNT];

    logic                w_pop;
    logic [MIDX_W:0]     w_bit_pos;
    logic [MASK_W-1:0]   w_mask_next;
    logic                w_full;
    logic                w_emit;
    logic                w_last;
    logic [31:0]         w_raw;
    logic signed [15:0]  w_q;
    logic signed [15:0]  w_acc;
    logic signed [16:0]  w_diff;
    logic [16:0]         w_mag;
    logic                w_take_new;
    t_result             w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit  <= JUMP_LIMIT_RST;
            r_temp_offset <= TEMP_OFFSET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_JUMP_LIMIT: begin
                    r_jump_limit <= i_cfg.data;
                end
                CFG_TEMP_OFFSET: begin
                    r_temp_offset <= i_cfg.data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Command intake and received mask update.
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign w_pop       = o_cmd_ready && i_cmd_valid;
    assign w_bit_pos   = (i_cmd.kind == KIND_SPEED) ? {1'b0, i_cmd.motor} :
                         {1'b0, i_cmd.motor} + (MIDX_W+1)'(MOTOR_COUNT);
    assign w_mask_next = r_mask | (MASK_W'(1) << w_bit_pos);
    assign w_full      = &w_mask_next;

    // Per-motor store, written one frame at a time.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (i_cmd.kind == KIND_SPEED) begin
                r_raw_speed[i_cmd.motor]  <= i_cmd.payload[31:0];
                r_raw_torque[i_cmd.motor] <= i_cmd.payload[63:32];
            end else begin
                r_fault_words[i_cmd.motor] <= i_cmd.payload[31:0];
                r_motor_temp[i_cmd.motor]  <= i_cmd.payload[39:32];
                r_driver_temp[i_cmd.motor] <= i_cmd.payload[47:40];
                r_odometer[i_cmd.motor]    <= i_cmd.payload[63:48];
            end
        end
    end

    // Speed filter for the motor being emitted: truncate toward zero, then
    // compare the change against the jump limit.
    assign w_emit     = (r_state == ST_EMIT) && (!r_out_valid || i_res_ready);
    assign w_last     = (r_cnt == MIDX_W'(MOTOR_COUNT - 1));
    assign w_raw      = r_raw_speed[r_cnt];
    assign w_q        = signed'(w_raw[31:16] + {15'd0, w_raw[31] && (|w_raw[15:0])});
    assign w_acc      = r_acc_speed[r_cnt];
    assign w_diff     = {w_q[15], w_q} - {w_acc[15], w_acc};
    assign w_mag      = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_take_new = (w_mag < {1'b0, r_jump_limit});

    always_comb begin
        w_res.motor_index    = 3'(r_cnt);
        w_res.speed_rpm      = w_take_new ? w_q : w_acc;
        w_res.speed_rejected = !w_take_new;
        w_res.torque_q16     = signed'(r_raw_torque[r_cnt]);
        w_res.fault_code     = r_fault_words[r_cnt];
        w_res.motor_temp     = signed'({1'b0, r_motor_temp[r_cnt]} - {1'b0, r_temp_offset});
        w_res.driver_temp    = signed'({1'b0, r_driver_temp[r_cnt]} - {1'b0, r_temp_offset});
        w_res.odometer_raw   = r_odometer[r_cnt];
    end

    // Last accepted speed per motor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                r_acc_speed[m] <= '0;
            end
        end else if (w_emit && w_take_new) begin
            r_acc_speed[r_cnt] <= w_q;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_pop) begin
                        if (w_full) begin
                            r_mask  <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_mask <= w_mask_next;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_cnt <= w_last ? '0 : r_cnt + MIDX_W'(1);
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
                r_out_last  <= w_last;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_res_last  = r_out_last;

endmodule

>>> rtl/core/motor_feedback_frame_collector.sv
// Motor feedback frame collector.
// Slave stream (i_s_*): one feedback frame per transaction. A frame with a bad
// header or an unknown message id is taken and dropped. Speed/torque and status
// frames update the store of the addressed motor and mark it in a received mask.
// Master stream (o_m_*): when both frames of every motor have arrived, the mask
// clears and one result per motor is sent, motor 0 first; o_m_tlast marks the
// result of the last motor.
// Config port (i_cfg_*): index 0 is the speed jump limit, index 1 the temperature
// offset. o_cfg_ready is always high; write only while the block is idle.
// The frame that completes the mask passes the front register, the queue and the
// sequencer before its first result, then one result per cycle while the receiver
// takes them. Throughput: one frame per cycle while the queue has room; a
// completing frame keeps the back end busy until every motor is emitted, as the
// single filter and output register serve all motors in turn.
// A stalled receiver holds the output register; the two-entry command queue and
// the front register then fill and o_s_tready drops.
// Reset (synchronous, active low) clears the mask, the accepted speeds, the
// queue and the output, and loads the default limit of 500 and offset of 50.
module motor_feedback_frame_collector import mfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // header_first[7:0], header_second[15:8], message_id[23:16], payload[87:24]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // motor_index[2:0], speed_rpm[18:3], speed_rejected[19], torque_q16[51:20],
    // fault_code[83:52], motor_temp[92:84], driver_temp[101:93],
    // odometer_raw[117:102], zero[119:118]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    w_front_valid;
    logic    w_front_ready;
    t_cmd    w_front_cmd;
    logic    w_q_valid;
    logic    w_q_ready;
    t_cmd    w_q_cmd;
    t_cfg_wr w_cfg;
    t_result w_res;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    mfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    mfc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push       (w_front_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop        (w_q_cmd)
    );

    mfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res),
        .o_res_last  (o_m_tlast)
    );

    // Pack the result, zero-filled up to whole bytes.
    assign o_m_tdata = {(OUT_DATA_W - RES_W)'(0), w_res};

endmodule

>>> rtl/core/mfc_checker.sv
`include "motor_feedback_frame_collector_assert.svh"

module mfc_checker import mfc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    logic [2:0] w_motor;

    // Motor number of the result on the master stream.
    assign w_motor = o_m_tdata[2:0];

    // A stalled result keeps its value.
    `MFC_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))

    // The end-of-run marker is held along with the data.
    `MFC_ASSERT(a_last_hold, o_m_tvalid && !i_m_tready |=> $stable(o_m_tlast))

    // Motor numbers stay within the configured motor count.
    `MFC_ASSERT_MSG(a_motor_range, o_m_tvalid |-> ({1'b0, w_motor} < 4'(MOTOR_COUNT)), "motor index out of range")

    // The run ends exactly on the last motor.
    `MFC_ASSERT_MSG(a_last_motor, o_m_tvalid |-> (o_m_tlast == (w_motor == 3'(MOTOR_COUNT - 1))), "tlast misplaced")

    // Results of a run come in motor order.
    `MFC_ASSERT(a_motor_order, o_m_tvalid && $past(o_m_tvalid && i_m_tready && !o_m_tlast) |-> (w_motor == $past(w_motor) + 3'd1))

endmodule

bind motor_feedback_frame_collector mfc_checker u_mfc_checker (.*);

>>> bench/tb_motor_feedback_frame_collector.sv
module tb_motor_feedback_frame_collector;
    timeunit 1ns;
    timeprecision 1ps;

    import mfc_pkg::*;

    localparam int SPEED_SCALE   = 65536;
    localparam int IDLE_PERCENT  = 34;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int FRAMES_PER_SET = 2 * MOTOR_COUNT;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hff;

    // One expected motor report together with its end-of-run marker.
    typedef struct packed {
        t_result res;
        logic    last;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Expected behavior of the collector: stored frames, held speeds and settings.
    logic [31:0]        speed_store       [MOTOR_COUNT];
    logic [31:0]        torque_store      [MOTOR_COUNT];
    logic [31:0]        fault_store       [MOTOR_COUNT];
    logic [7:0]         motor_temp_store  [MOTOR_COUNT];
    logic [7:0]         driver_temp_store [MOTOR_COUNT];
    logic [15:0]        odo_store         [MOTOR_COUNT];
    logic signed [15:0] held_speed        [MOTOR_COUNT];
    logic [MASK_W-1:0]  arrived_mask;
    logic [15:0]        jump_limit_cfg;
    logic [7:0]         temp_offset_cfg;
    t_report            reports_due [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;
    int frames_sent = 0;
    int frames_ignored = 0;
    int reports_checked = 0;
    int speeds_held = 0;
    int cfg_writes = 0;

    t_result seen_report;
    t_report due_report;

    motor_feedback_frame_collector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Store one accepted frame and, when every motor has both frames, queue the reports.
    task automatic apply_frame(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] id, input logic [63:0] pl);
        int m;
        int q;
        int diff;
        int mt;
        int dt;
        t_report rep;
        frames_sent++;
        if (h0 != HDR_FIRST || h1 != HDR_SECOND) begin
            frames_ignored++;
            return;
        end
        if (id >= ID_SPEED_BASE && id < ID_SPEED_BASE + MOTOR_COUNT) begin
            m = id - ID_SPEED_BASE;
            speed_store[m]  = pl[31:0];
            torque_store[m] = pl[63:32];
            arrived_mask[m] = 1'b1;
        end else if (id >= ID_STATUS_BASE && id < ID_STATUS_BASE + MOTOR_COUNT) begin
            m = id - ID_STATUS_BASE;
            fault_store[m]       = pl[31:0];
            motor_temp_store[m]  = pl[39:32];
            driver_temp_store[m] = pl[47:40];
            odo_store[m]         = pl[63:48];
            arrived_mask[MOTOR_COUNT + m] = 1'b1;
        end else begin
            frames_ignored++;
            return;
        end
        if (!(&arrived_mask))
            return;
        arrived_mask = '0;
        for (m = 0; m < MOTOR_COUNT; m++) begin
            // Integer rpm truncates toward zero; the jump filter needs a strictly smaller step.
            q = $signed(speed_store[m]) / SPEED_SCALE;
            diff = q - held_speed[m];
            if (diff < 0)
                diff = -diff;
            rep.res.speed_rejected = (diff >= int'(jump_limit_cfg));
            if (rep.res.speed_rejected)
                speeds_held++;
            else
                held_speed[m] = q[15:0];
            mt = int'(motor_temp_store[m]) - int'(temp_offset_cfg);
            dt = int'(driver_temp_store[m]) - int'(temp_offset_cfg);
            rep.res.motor_index  = m[2:0];
            rep.res.speed_rpm    = held_speed[m];
            rep.res.torque_q16   = torque_store[m];
            rep.res.fault_code   = fault_store[m];
            rep.res.motor_temp   = mt[8:0];
            rep.res.driver_temp  = dt[8:0];
            rep.res.odometer_raw = odo_store[m];
            rep.last = (m == MOTOR_COUNT - 1);
            reports_due.push_back(rep);
        end
    endtask

    // Offer one frame on the slave stream and wait for its transaction.
    task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                              input logic [7:0] id, input logic [63:0] pl);
        @(negedge i_clk);
        while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pl, id, h1, h0};
        do @(posedge i_clk); while (!o_s_tready);
        apply_frame(h0, h1, id, pl);
    endtask

    task automatic send_good(input logic [7:0] id, input logic [63:0] pl);
        send_frame(HDR_FIRST, HDR_SECOND, id, pl);
    endtask

    // Write one configuration register through the config channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JUMP_LIMIT:  jump_limit_cfg = data;
            CFG_TEMP_OFFSET: temp_offset_cfg = data[7:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering frames, let all reports drain and the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Speeds cluster around the held value so that both filter outcomes are common.
    function automatic logic [31:0] pick_speed(input int m);
        int rpm;
        int span;
        span = int'(jump_limit_cfg) + 2;
        case ($urandom_range(3))
            0: return $urandom;
            1: rpm = int'($urandom_range(1200)) - 600;
            default: rpm = held_speed[m] + int'($urandom_range(2 * span)) - span;
        endcase
        return {rpm[15:0], 16'($urandom)};
    endfunction

    task automatic send_content(input logic [7:0] id);
        logic [63:0] pl;
        if (id >= ID_SPEED_BASE)
            pl = {32'($urandom), pick_speed(id - ID_SPEED_BASE)};
        else
            pl = {16'($urandom), 8'($urandom), 8'($urandom), 32'($urandom)};
        send_good(id, pl);
    endtask

    // Random header, id and payload; half of them carry a good header.
    task automatic send_noise();
        logic [7:0] h0;
        logic [7:0] h1;
        h0 = $urandom;
        h1 = $urandom;
        if ($urandom_range(1)) begin
            h0 = HDR_FIRST;
            h1 = HDR_SECOND;
        end
        send_frame(h0, h1, 8'($urandom), {32'($urandom), 32'($urandom)});
    endtask

    // Every id of every motor in shuffled order, with repeats and noise mixed in.
    task automatic send_random_set();
        logic [7:0] ids [FRAMES_PER_SET];
        logic [7:0] swap;
        int j;
        int k;
        for (k = 0; k < MOTOR_COUNT; k++) begin
            ids[k] = ID_SPEED_BASE + 8'(k);
            ids[MOTOR_COUNT + k] = ID_STATUS_BASE + 8'(k);
        end
        for (k = FRAMES_PER_SET - 1; k > 0; k--) begin
            j = $urandom_range(k);
            swap = ids[k];
            ids[k] = ids[j];
            ids[j] = swap;
        end
        for (k = 0; k < FRAMES_PER_SET; k++) begin
            if ($urandom_range(9) == 0)
                send_noise();
            if (k > 0 && $urandom_range(11) == 0)
                send_content(ids[$urandom_range(k - 1)]);
            send_content(ids[k]);
        end
    endtask

    // Dropped frames, an overwritten frame and one full set at the field extremes.
    task automatic test_directed_frames();
        send_frame(8'hf7, HDR_SECOND, ID_SPEED_BASE, '1);
        send_frame(HDR_FIRST, 8'hff, ID_STATUS_BASE, '1);
        send_good(ID_SPEED_BASE - 8'd1, '1);
        send_good(ID_SPEED_BASE + 8'(MOTOR_COUNT), '1);
        send_good(ID_STATUS_BASE - 8'd1, '0);
        send_good(ID_STATUS_BASE + 8'(MOTOR_COUNT), '0);
        send_good(ID_SPEED_BASE + 8'd0, {32'h7fff_ffff, 32'h7fff_ffff});
        send_good(ID_SPEED_BASE + 8'd1, {32'h8000_0000, 32'h8000_0000});
        send_good(ID_STATUS_BASE + 8'd0, {16'hffff, 8'hff, 8'hff, 32'hffff_ffff});
        send_good(ID_SPEED_BASE + 8'd2, {32'h0000_0000, 32'hfffe_8000});
        // This speed frame is replaced before the set completes.
        send_good(ID_SPEED_BASE + 8'd5, {32'hdead_beef, 32'h1234_5678});
        send_good(ID_SPEED_BASE + 8'd3, {32'hffff_ffff, 32'h01f3_ffff});
        send_good(ID_SPEED_BASE + 8'd4, {32'h0001_0000, 32'h01f4_0000});
        send_good(ID_STATUS_BASE + 8'd1, {16'h0000, 8'h00, 8'h00, 32'h0000_0000});
        send_good(ID_STATUS_BASE + 8'd2, {16'h8000, 8'd49, 8'd50, 32'h8000_0000});
        send_good(ID_STATUS_BASE + 8'd3, {16'h0001, 8'd255, 8'd0, 32'h0000_0001});
        send_good(ID_STATUS_BASE + 8'd4, {16'h5a5a, 8'h5a, 8'ha5, 32'ha5a5_5a5a});
        send_good(ID_SPEED_BASE + 8'd5, {32'hffff_0000, 32'hffff_ffff});
        send_good(ID_STATUS_BASE + 8'd5, {16'ha5a5, 8'ha5, 8'h5a, 32'h5a5a_a5a5});
    endtask

    // The receiver stalls for a long stretch while frames keep coming.
    task automatic test_receiver_hold();
        wait_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        @(posedge i_clk);
        rx_hold_left = HOLD_CYCLES;
        repeat (3) send_random_set();
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Random sets under a sequence of register settings, extremes included.
    task automatic test_random_sets();
        int phase;
        for (phase = 0; phase < 7; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(CFG_JUMP_LIMIT, 16'h0000);
                    write_reg(CFG_TEMP_OFFSET, 16'h00ff);
                end
                1: begin
                    write_reg(CFG_JUMP_LIMIT, 16'hffff);
                    write_reg(CFG_TEMP_OFFSET, 16'h0000);
                end
                2: begin
                    write_reg(CFG_UNUSED_IDX, 16'($urandom));
                    write_reg(CFG_JUMP_LIMIT, 16'($urandom));
                    write_reg(CFG_TEMP_OFFSET, 16'($urandom));
                end
                3: begin
                    write_reg(CFG_JUMP_LIMIT, JUMP_LIMIT_RST);
                    write_reg(CFG_TEMP_OFFSET, 16'(TEMP_OFFSET_RST));
                end
                4: begin
                    write_reg(CFG_JUMP_LIMIT, 16'(1 + $urandom_range(2000)));
                    write_reg(CFG_TEMP_OFFSET, 16'($urandom));
                end
                5: begin
                    write_reg(CFG_JUMP_LIMIT, 16'h0001);
                    write_reg(CFG_TEMP_OFFSET, 16'h0080);
                end
                default: begin
                    write_reg(CFG_JUMP_LIMIT, 16'($urandom_range(4000)));
                    write_reg(CFG_TEMP_OFFSET, 16'($urandom));
                end
            endcase
            // The reset-value phase runs with both streams at full rate.
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            repeat (2) send_random_set();
        end
    endtask

    // Receiver: random stalls, a counted hold-off on request, or always ready.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_idle_on) begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare every report transaction with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_report = t_result'(o_m_tdata[RES_W-1:0]);
            if (reports_due.size() == 0) begin
                errors++;
                $display("%0t: motor report with none expected, actual %h", $time, o_m_tdata);
            end else begin
                due_report = reports_due.pop_front();
                reports_checked++;
                check_field("motor_index", due_report.res.motor_index, seen_report.motor_index);
                check_field("speed_rpm", due_report.res.speed_rpm, seen_report.speed_rpm);
                check_field("speed_rejected", due_report.res.speed_rejected,
                            seen_report.speed_rejected);
                check_field("torque_q16", due_report.res.torque_q16, seen_report.torque_q16);
                check_field("fault_code", due_report.res.fault_code, seen_report.fault_code);
                check_field("motor_temp", due_report.res.motor_temp, seen_report.motor_temp);
                check_field("driver_temp", due_report.res.driver_temp,
                            seen_report.driver_temp);
                check_field("odometer_raw", due_report.res.odometer_raw,
                            seen_report.odometer_raw);
                check_field("last_of_run", due_report.last, o_m_tlast);
            end
        end
    end

    // Watchdog on cycles without any transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d reports still due",
                         $time, STALL_LIMIT, reports_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        speed_store       = '{default: '0};
        torque_store      = '{default: '0};
        fault_store       = '{default: '0};
        motor_temp_store  = '{default: '0};
        driver_temp_store = '{default: '0};
        odo_store         = '{default: '0};
        held_speed        = '{default: '0};
        arrived_mask      = '0;
        jump_limit_cfg    = JUMP_LIMIT_RST;
        temp_offset_cfg   = TEMP_OFFSET_RST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_receiver_hold();
        test_random_sets();
        wait_idle();

        $display("Run covered %0d frames (%0d dropped) and %0d motor reports, %0d with held speed,",
                 frames_sent, frames_ignored, reports_checked, speeds_held);
        $display("across %0d register writes including zero and full-scale jump limits.",
                 cfg_writes);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
